/* hdl/rmts_pkg.sv */
// ----------------------------------------------------------------------------
// Rate-monotonic task scheduler package
// Shared types, codes and helpers for the scheduler controller and datapath.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int SLOT_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_SEL,
    ST_SCAN_DL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  task_index;
    logic [15:0] task_period;
    logic [15:0] task_burst;
    logic [31:0] task_arrival;
  } in_item_t;

  typedef struct packed {
    logic        ran;
    logic [2:0]  ran_task;
    logic [7:0]  miss_mask;
    logic [31:0] now;
    logic [31:0] busy_count;
    logic [15:0] read_remaining;
    logic [15:0] read_misses;
  } out_item_t;

  typedef struct packed {
    logic accept;    // latch the incoming word, clear the scan
    logic sel_step;  // release and priority-select pass, one slot
    logic dl_step;   // run and deadline pass, one slot
    logic finish;    // commit the operation and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] idx);
    return SLOT_W'(idx);
  endfunction

endpackage

/* hdl/rmts_ctrl.sv */
// ----------------------------------------------------------------------------
// Rate-monotonic scheduler controller
// Sequences the two slot passes of a tick and the load and read operations.
// ----------------------------------------------------------------------------
module rmts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_func_i,
  input  rmts_pkg::ctrl_sts_t   sts_i,
  output logic                  in_stall_o,
  output rmts_pkg::ctrl_cmd_t   cmd_o
);

  rmts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_func_i == rmts_pkg::FUNC_TICK) ? rmts_pkg::ST_SCAN_SEL
                                                       : rmts_pkg::ST_FINISH;
        end
      end
      rmts_pkg::ST_SCAN_SEL: begin
        if (sts_i.scan_last) state_d = rmts_pkg::ST_SCAN_DL;
      end
      rmts_pkg::ST_SCAN_DL: begin
        if (sts_i.scan_last) state_d = rmts_pkg::ST_FINISH;
      end
      rmts_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = rmts_pkg::ST_IDLE;
      end
      default: state_d = rmts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      rmts_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      rmts_pkg::ST_SCAN_SEL: cmd_o.sel_step = 1'b1;
      rmts_pkg::ST_SCAN_DL:  cmd_o.dl_step  = 1'b1;
      rmts_pkg::ST_FINISH:   cmd_o.finish   = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hdl/rmts_datapath.sv */
// ----------------------------------------------------------------------------
// Rate-monotonic scheduler datapath
// Task table, time and busy counters, one-slot-per-cycle scan and output word.
// ----------------------------------------------------------------------------
module rmts_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rmts_pkg::in_item_t    in_data_i,
  input  rmts_pkg::ctrl_cmd_t   cmd_i,
  input  logic                  out_stall_i,
  output rmts_pkg::ctrl_sts_t   sts_o,
  output logic                  out_valid_o,
  output rmts_pkg::out_item_t   out_data_o
);

  localparam int N = rmts_pkg::NUM_TASKS;
  localparam int W = rmts_pkg::SLOT_W;

  // Task table.
  logic [N-1:0] loaded_q;
  logic [15:0]  period_q   [N];
  logic [15:0]  burst_q    [N];
  logic [31:0]  arrival_q  [N];
  logic [31:0]  deadline_q [N];
  logic [15:0]  remain_q   [N];
  logic [15:0]  miss_q     [N];

  logic [31:0]        time_q, busy_q;
  rmts_pkg::in_item_t item_q;
  logic [W-1:0]       scan_q, best_q;
  logic               found_q;
  logic [15:0]        best_per_q;
  logic [7:0]         mask_q;
  logic               out_valid_q;
  rmts_pkg::out_item_t out_q;

  logic [W-1:0] addr;
  logic         rd_loaded;
  logic [15:0]  rd_per, rd_bur, rd_rem, rd_miss, rem_eff;
  logic [31:0]  rd_arr, rd_dl, rel_dl, next_dl, busy_nx;
  logic         arrived, sel_take, is_best, dl_hit, dl_miss, idx_ok, is_tick, scan_last;
  rmts_pkg::out_item_t out_d;

  assign scan_last = (scan_q == W'(N - 1));
  assign addr      = (cmd_i.sel_step || cmd_i.dl_step) ? scan_q
                                                       : rmts_pkg::slot_of(item_q.task_index);
  assign idx_ok    = (int'(item_q.task_index) < N);
  assign is_tick   = (item_q.func == rmts_pkg::FUNC_TICK);

  assign rd_loaded = loaded_q[addr];
  assign rd_per    = period_q[addr];
  assign rd_bur    = burst_q[addr];
  assign rd_arr    = arrival_q[addr];
  assign rd_dl     = deadline_q[addr];
  assign rd_rem    = remain_q[addr];
  assign rd_miss   = miss_q[addr];

  assign rel_dl   = rd_arr + 32'(rd_per);
  assign next_dl  = time_q + 32'(rd_per);
  assign arrived  = (rd_arr <= time_q);
  assign sel_take = rd_loaded && arrived && (rd_rem != 16'd0) &&
                    (!found_q || (rd_per < best_per_q));

  // The selected task runs its unit within the deadline pass.
  assign is_best  = found_q && (addr == best_q);
  assign rem_eff  = is_best ? (rd_rem - 16'd1) : rd_rem;
  assign dl_hit   = rd_loaded && (rd_dl == time_q);
  assign dl_miss  = dl_hit && arrived && (rem_eff != 16'd0);

  assign busy_nx  = (is_tick && found_q && (busy_q != '1)) ? (busy_q + 32'd1) : busy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_step && rd_loaded && (rd_arr == time_q)) begin
      deadline_q[addr] <= rel_dl;
    end
    if (cmd_i.dl_step) begin
      if (dl_hit) begin
        remain_q[addr]   <= rd_bur;
        deadline_q[addr] <= next_dl;
        if (dl_miss && (rd_miss != 16'hFFFF)) miss_q[addr] <= rd_miss + 16'd1;
      end else if (is_best) begin
        remain_q[addr] <= rem_eff;
      end
    end
    if (cmd_i.finish && (item_q.func == rmts_pkg::FUNC_LOAD) && idx_ok) begin
      period_q[addr]   <= item_q.task_period;
      burst_q[addr]    <= item_q.task_burst;
      arrival_q[addr]  <= item_q.task_arrival;
      deadline_q[addr] <= item_q.task_arrival + 32'(item_q.task_period);
      remain_q[addr]   <= item_q.task_burst;
      miss_q[addr]     <= 16'd0;
    end
    if (cmd_i.accept) item_q <= in_data_i;
    if (cmd_i.sel_step && sel_take) best_per_q <= rd_per;
    if (cmd_i.finish) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      time_q      <= '0;
      busy_q      <= '0;
      scan_q      <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        scan_q  <= '0;
        found_q <= 1'b0;
        best_q  <= '0;
        mask_q  <= '0;
      end
      if (cmd_i.sel_step || cmd_i.dl_step) begin
        scan_q <= scan_last ? '0 : (scan_q + W'(1));
      end
      if (cmd_i.sel_step && sel_take) begin
        found_q <= 1'b1;
        best_q  <= addr;
      end
      if (cmd_i.dl_step && dl_miss && (int'(scan_q) < 8)) begin
        mask_q[3'(scan_q)] <= 1'b1;
      end
      if (cmd_i.finish) begin
        if ((item_q.func == rmts_pkg::FUNC_LOAD) && idx_ok) loaded_q[addr] <= 1'b1;
        if (is_tick) time_q <= time_q + 32'd1;
        busy_q <= busy_nx;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_d                = '0;
    out_d.now            = time_q;
    out_d.busy_count     = busy_nx;
    if (is_tick) begin
      out_d.ran       = found_q;
      out_d.ran_task  = found_q ? 3'(best_q) : 3'd0;
      out_d.miss_mask = mask_q;
    end
    if ((item_q.func == rmts_pkg::FUNC_READ) && idx_ok && rd_loaded) begin
      out_d.read_remaining = rd_rem;
      out_d.read_misses    = rd_miss;
    end
  end

  assign sts_o.scan_last = scan_last;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

/* hdl/rate_monotonic_task_scheduler.sv */
// A tick runs one slot pass for release and priority select, then one slot pass for the
// run and the deadline checks, each one slot a cycle. A load or a read skips the passes.
// One word is in work at a time; the output register lets the next word be taken while
// a result waits. Reset clears the loaded flags, the time and the busy counters at once;
// the task table itself is not cleared.
// ----------------------------------------------------------------------------
// Rate-monotonic task scheduler
// Periodic task table with smallest-period selection and deadline miss counting.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rmts_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rmts_pkg::out_item_t  out_data_o
);

  rmts_pkg::ctrl_cmd_t cmd;
  rmts_pkg::ctrl_sts_t sts;

  rmts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rmts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
